### hw/rtl/kds_pkg.sv
// Shared types and constants for the single-key keypad debouncer.
package kds_pkg;

   // Widths of the snapshot and the agreement counter.
   localparam int KEY_WIDTH   = 16;
   localparam int COUNT_WIDTH = 7;
   localparam int COLS        = 4;

   // Default number of scanned rows.
   localparam int ROWS_DEFAULT = 4;

   // Depth of the result queue.
   localparam int FIFO_DEPTH = 4;

   // Counter constants.
   localparam logic [COUNT_WIDTH-1:0] AGREE_MAX       = 7'd100;
   localparam logic [COUNT_WIDTH-1:0] MULTI_KEY_COUNT = 7'd5;
   localparam logic [COUNT_WIDTH-1:0] DEBOUNCE_RESET  = 7'd4;

   // One result from the debounce logic toward the result queue.
   typedef struct packed {
      logic                 valid;
      logic [KEY_WIDTH-1:0] pattern;
   } kds_result_type;

endpackage

### hw/rtl/kds_core.sv
// Debounce state and per-snapshot update logic.
module kds_core
   import kds_pkg::*;
#(
   parameter int ROWS = ROWS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  logic [KEY_WIDTH-1:0]   key_bits,
   input  logic [COUNT_WIDTH-1:0] debounce_count,
   output kds_result_type         result
);

   localparam int MaskBits = (ROWS * COLS >= KEY_WIDTH) ? KEY_WIDTH : ROWS * COLS;
   localparam logic [KEY_WIDTH-1:0] SnapMask = KEY_WIDTH'((33'd1 << MaskBits) - 33'd1);

   logic [KEY_WIDTH-1:0]   previous_pattern_ff;
   logic [KEY_WIDTH-1:0]   previous_pattern_in;
   logic [COUNT_WIDTH-1:0] agree_count_ff;
   logic [COUNT_WIDTH-1:0] agree_count_in;
   logic                   lockout_ff;
   logic                   lockout_in;

   logic [KEY_WIDTH-1:0]   snap;
   logic                   multi_key;
   logic                   all_up;
   logic                   lockout_next;
   logic [COUNT_WIDTH-1:0] count_after_multi;
   logic [COUNT_WIDTH-1:0] count_inc;

   // Mask unused rows; two or more keys down leaves a bit after clearing the lowest one.
   assign snap      = key_bits & SnapMask;
   assign multi_key = (snap & (snap - KEY_WIDTH'(1))) != '0;
   assign all_up    = (snap == '0);

   // Lockout and count after the multi-key check.
   always_comb begin
      lockout_next      = lockout_ff;
      count_after_multi = agree_count_ff;
      if (multi_key) begin
         lockout_next      = 1'b1;
         count_after_multi = MULTI_KEY_COUNT;
      end else if (all_up) begin
         lockout_next = 1'b0;
      end
   end

   assign count_inc = count_after_multi + COUNT_WIDTH'(1);

   // Agreement tracking and report decision.
   always_comb begin
      previous_pattern_in = previous_pattern_ff;
      agree_count_in      = agree_count_ff;
      lockout_in          = lockout_ff;
      result.valid        = 1'b0;
      result.pattern      = snap;
      if (item_valid) begin
         lockout_in     = lockout_next;
         agree_count_in = count_after_multi;
         if (snap != previous_pattern_ff) begin
            agree_count_in      = '0;
            previous_pattern_in = snap;
         end else if (!all_up && !lockout_next && count_after_multi < AGREE_MAX) begin
            agree_count_in = count_inc;
            result.valid   = (count_inc == debounce_count);
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         previous_pattern_ff <= '0;
         agree_count_ff      <= '0;
         lockout_ff          <= 1'b1;
      end else begin
         previous_pattern_ff <= previous_pattern_in;
         agree_count_ff      <= agree_count_in;
         lockout_ff          <= lockout_in;
      end
   end

   // The counter saturates at its ceiling.
   assert property (@(posedge clock) disable iff (reset) agree_count_ff <= AGREE_MAX)
      else $error("agreement count above ceiling");

   // Several keys down always raise the lockout.
   assert property (@(posedge clock) disable iff (reset)
      item_valid && multi_key |=> lockout_ff)
      else $error("lockout not raised on multiple keys");

   // A report leaves the lockout clear and the count at the threshold.
   assert property (@(posedge clock) disable iff (reset)
      result.valid |=> !lockout_ff && agree_count_ff == $past(debounce_count))
      else $error("report without matching count");

endmodule

### hw/rtl/kds_out_fifo.sv
// Small result queue that decouples the debounce logic from the receiver.
module kds_out_fifo
   import kds_pkg::*;
#(
   parameter int DEPTH = FIFO_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  kds_result_type               push,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [KEY_WIDTH-1:0]         out_data,
   output logic [$clog2(DEPTH+1)-1:0]   level
);

   localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LevelWidth = $clog2(DEPTH + 1);

   logic [KEY_WIDTH-1:0]  mem [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff;
   logic [PtrWidth-1:0]   wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff;
   logic [PtrWidth-1:0]   rd_ptr_in;
   logic [LevelWidth-1:0] level_ff;
   logic [LevelWidth-1:0] level_in;
   logic                  pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (level_ff != '0);
   assign out_data  = mem[rd_ptr_ff];
   assign level     = level_ff;

   // Pointer and fill level updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      unique case ({push.valid, pop})
         2'b10:   level_in = level_ff + LevelWidth'(1);
         2'b01:   level_in = level_ff - LevelWidth'(1);
         default: level_in = level_ff;
      endcase
   end

   // Storage write.
   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem[wr_ptr_ff] <= push.pattern;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // The fill level never passes the depth.
   assert property (@(posedge clock) disable iff (reset) level_ff <= LevelWidth'(DEPTH))
      else $error("result queue overfilled");

   // No push into a full queue.
   assert property (@(posedge clock) disable iff (reset)
      push.valid |-> level_ff != LevelWidth'(DEPTH))
      else $error("push into full result queue");

endmodule

### hw/rtl/keypad_debounce_single_key.sv
// Usage:
// Debounces a scanned key matrix and reports a single key press once.
// req channel: one transaction carries one full matrix snapshot in tdata;
// the first scanned row sits in bits 3:0, four column bits per row.
// rsp channel: one transaction carries the debounced single-key pattern,
// at most one per snapshot and once per press.
// csr channel: writes the debounce threshold; csr_ready is always high.
// Write it only while no snapshot is in flight.
// Path: an accepted snapshot is registered, evaluated against the debounce
// state, and its result is written into the result queue, which offers it
// on rsp.
// Throughput: one snapshot per cycle while req_tready is high.
// A four-entry result queue absorbs results while the receiver stalls;
// req_tready drops only when the queue plus the snapshot in flight
// would fill it.
// Reset: threshold returns to 4, stored pattern and count clear, the
// multi-key lockout is set, and the pipeline and queue empty.
module keypad_debounce_single_key
   import kds_pkg::*;
#(
   parameter int ROWS = ROWS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [KEY_WIDTH-1:0]   req_tdata,   // [15:0] key_bits
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [KEY_WIDTH-1:0]   rsp_tdata,   // [15:0] key_pattern
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [COUNT_WIDTH-1:0] csr_data     // [6:0] debounce_count
);

   localparam int LevelWidth = $clog2(FIFO_DEPTH + 1);

   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [KEY_WIDTH-1:0]   in_bits_ff;
   logic [COUNT_WIDTH-1:0] debounce_count_ff;
   logic [COUNT_WIDTH-1:0] debounce_count_in;
   logic [LevelWidth-1:0]  level;
   kds_result_type         result;

   // Accept while the queue can hold a result for every snapshot in flight.
   assign req_tready  = (LevelWidth'(in_valid_ff) + level) < LevelWidth'(FIFO_DEPTH);
   assign in_valid_in = req_tvalid && req_tready;

   // Threshold register.
   assign csr_ready         = 1'b1;
   assign debounce_count_in = csr_valid ? csr_data : debounce_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         debounce_count_ff <= DEBOUNCE_RESET;
      end else begin
         in_valid_ff       <= in_valid_in;
         debounce_count_ff <= debounce_count_in;
      end
   end

   // Input payload register.
   always_ff @(posedge clock) begin
      if (in_valid_in) begin
         in_bits_ff <= req_tdata;
      end
   end

   kds_core #(
      .ROWS (ROWS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (in_valid_ff),
      .key_bits       (in_bits_ff),
      .debounce_count (debounce_count_ff),
      .result         (result)
   );

   kds_out_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata),
      .level     (level)
   );

endmodule

### tb/keypad_debounce_single_key_test.sv
// Self-checking testbench for the single-key keypad debouncer, with a predicting scoreboard.
`timescale 1ns / 100ps

module keypad_debounce_single_key_test;
   import kds_pkg::*;

   // Predicts debounced key presses and holds the ones still to arrive.
   class press_scoreboard;
      logic [KEY_WIDTH-1:0]   expected_presses[$];
      logic [KEY_WIDTH-1:0]   stored_snapshot;
      logic [COUNT_WIDTH-1:0] agree_cnt;
      logic [COUNT_WIDTH-1:0] threshold;
      bit                     locked;
      int                     mismatches;

      function new();
         threshold       = DEBOUNCE_RESET;
         stored_snapshot = '0;
         agree_cnt       = '0;
         locked          = 1'b1;
         mismatches      = 0;
      endfunction

      function void set_threshold(input logic [COUNT_WIDTH-1:0] value);
         threshold = value;
      endfunction

      function int pending();
         return expected_presses.size();
      endfunction

      // Applies one accepted snapshot to the debounce state.
      function void predict_press(input logic [KEY_WIDTH-1:0] key_bits);
         logic [KEY_WIDTH-1:0] used_mask;
         logic [KEY_WIDTH-1:0] snap;
         used_mask = (ROWS_DEFAULT * COLS >= KEY_WIDTH) ? {KEY_WIDTH{1'b1}}
                     : KEY_WIDTH'((1 << (ROWS_DEFAULT * COLS)) - 1);
         snap = key_bits & used_mask;
         // Two or more keys force the count and raise the lockout; all up clears it.
         if ($countones(snap) >= 2) begin
            agree_cnt = MULTI_KEY_COUNT;
            locked    = 1'b1;
         end else if (snap == '0) begin
            locked = 1'b0;
         end
         // A changed snapshot restarts agreement; a steady single key counts up.
         if (snap != stored_snapshot) begin
            agree_cnt       = '0;
            stored_snapshot = snap;
         end else if (snap != '0 && !locked) begin
            if (agree_cnt < AGREE_MAX) begin
               agree_cnt = agree_cnt + 1'b1;
               if (agree_cnt == threshold) begin
                  expected_presses.push_back(snap);
               end
            end
         end
      endfunction

      task report_mismatch(input string what);
         $display("ERROR at %0t: %s", $realtime, what);
         mismatches++;
      endtask

      // Compares one received pattern with the oldest predicted press.
      task check_pattern(input logic [KEY_WIDTH-1:0] got);
         logic [KEY_WIDTH-1:0] want;
         if (expected_presses.size() == 0) begin
            report_mismatch($sformatf("unexpected key_pattern %h", got));
         end else begin
            want = expected_presses.pop_front();
            if (got !== want) begin
               report_mismatch($sformatf("key_pattern %h, predicted %h", got, want));
            end
         end
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [KEY_WIDTH-1:0]   req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [KEY_WIDTH-1:0]   rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [COUNT_WIDTH-1:0] csr_data = '0;

   press_scoreboard presses = new();
   int tx_idle_pct = 0;
   int rx_stall_pct = 0;
   int snapshots_sent = 0;

   keypad_debounce_single_key dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [15:0] key_bits
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [15:0] key_pattern
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)      // [6:0] debounce_count
   );

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver stalls at random according to the current phase.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
   end

   // Every result transaction is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         presses.check_pattern(rsp_tdata);
      end
   end

   // Sends one snapshot transaction, with random idle cycles ahead of it.
   task automatic send_snapshot(input logic [KEY_WIDTH-1:0] bits);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= bits;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      presses.predict_press(bits);
      snapshots_sent++;
   endtask

   // Lets the block drain so that the threshold can be changed safely.
   task automatic settle();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      repeat (4) @(posedge clock);
      while (presses.pending() != 0 && guard < 2000) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [COUNT_WIDTH-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      presses.set_threshold(value);
      csr_valid <= 1'b0;
   endtask

   // Mostly clean presses of one key, plus chatter, multi-key presses and noise.
   task automatic run_phase(input int thr, input int tx_pct, input int rx_pct,
                            input int budget);
      int stop_at;
      int kind;
      int hold;
      int a;
      int b;
      logic [KEY_WIDTH-1:0] key;
      logic [KEY_WIDTH-1:0] multi;
      write_threshold(COUNT_WIDTH'(thr));
      tx_idle_pct  = tx_pct;
      rx_stall_pct = rx_pct;
      stop_at = snapshots_sent + budget;
      while (snapshots_sent < stop_at) begin
         kind = $urandom_range(99);
         if (kind < 70) begin
            key = KEY_WIDTH'(1) << $urandom_range(KEY_WIDTH - 1);
            if ($urandom_range(3) == 0) begin
               hold = $urandom_range(1, 8);
            end else if (thr >= 10 && thr <= AGREE_MAX) begin
               hold = $urandom_range(thr - 3, thr + 8);
            end else begin
               hold = $urandom_range(1, 12);
            end
            // Contact bounce ahead of the steady press.
            if ($urandom_range(4) == 0) begin
               repeat ($urandom_range(1, 3)) begin
                  send_snapshot(($urandom_range(1) == 0) ? '0 : key);
               end
            end
            repeat (hold + 1) send_snapshot(key);
            repeat ($urandom_range(1, 3)) send_snapshot('0);
         end else if (kind < 85) begin
            a = $urandom_range(KEY_WIDTH - 1);
            b = (a + 1 + $urandom_range(KEY_WIDTH - 2)) % KEY_WIDTH;
            multi = KEY_WIDTH'($urandom_range(65535)) | (KEY_WIDTH'(1) << a)
                    | (KEY_WIDTH'(1) << b);
            repeat ($urandom_range(1, 4)) send_snapshot(multi);
            // Dropping back to one key keeps the lockout until all keys are up.
            if ($urandom_range(1) == 0) begin
               repeat ($urandom_range(1, 8)) send_snapshot(KEY_WIDTH'(1) << a);
            end
            if ($urandom_range(3) != 0) begin
               send_snapshot('0);
            end
         end else begin
            send_snapshot(KEY_WIDTH'($urandom_range(65535)));
         end
      end
   endtask

   // Main sequence: reset, directed cases, then randomized phases.
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A key held while locked from reset is never reported.
      repeat (5) send_snapshot(16'h8000);
      send_snapshot(16'h0000);
      // Clean press at the reset threshold, reported once only.
      repeat (6) send_snapshot(16'h0001);
      send_snapshot(16'h0000);
      // Multi-key press, then one key still down under lockout.
      repeat (2) send_snapshot(16'h8001);
      repeat (3) send_snapshot(16'h8000);
      send_snapshot(16'hFFFF);
      send_snapshot(16'h0000);
      // Lowest threshold reports on the first repeat.
      write_threshold(COUNT_WIDTH'(1));
      repeat (2) send_snapshot(16'h0010);
      send_snapshot(16'h0000);

      run_phase(1, 0, 0, 120);
      run_phase(3, 80, 0, 120);
      run_phase(99, 0, 80, 230);
      run_phase(AGREE_MAX, 8, 8, 230);
      run_phase(0, 0, 0, 80);
      run_phase(127, 80, 0, 80);
      run_phase($urandom_range(2, 12), 0, 80, 150);
      run_phase(MULTI_KEY_COUNT, 8, 8, 150);

      settle();
      if (presses.pending() != 0) begin
         presses.report_mismatch($sformatf("%0d predicted presses never arrived",
                                           presses.pending()));
      end
      if (presses.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/kds_pkg.sv
hw/rtl/kds_core.sv
hw/rtl/kds_out_fifo.sv
hw/rtl/keypad_debounce_single_key.sv
tb/keypad_debounce_single_key_test.sv
